>>> rtl/core/rwcp_pkg.sv
// Shared types and constants for the RIFF/WAVE chunk header parser.
`timescale 1ns / 1ps
`default_nettype none

package rwcp_pkg;

  typedef enum logic [1:0] {
    PH_RIFF   = 2'd0,
    PH_HEADER = 2'd1,
    PH_FMT    = 2'd2,
    PH_SKIP   = 2'd3
  } phase_t;

  typedef struct packed {
    phase_t      phase;
    logic [3:0]  shift;
    logic [31:0] tag;
    logic [31:0] size;
    logic [32:0] skip;
    logic [31:0] pos;
    logic        fmt_seen;
    logic        decided;
  } state_t;

  typedef struct packed {
    logic        valid;
    logic        ok;
    logic [31:0] offset;
    logic [31:0] length;
  } res_t;

  localparam logic [1:0] REG_BUFFER_LENGTH = 2'd0;
  localparam logic [1:0] REG_EXPECTED_RATE = 2'd1;

  localparam logic [31:0] BUFFER_LENGTH_RST = 32'd512;
  localparam logic [31:0] EXPECTED_RATE_RST = 32'd16000;

  localparam state_t STATE_RST = '{
    phase:    PH_RIFF,
    shift:    4'd0,
    tag:      32'd0,
    size:     32'd0,
    skip:     33'd0,
    pos:      32'd0,
    fmt_seen: 1'b0,
    decided:  1'b0
  };

endpackage

`default_nettype wire

>>> rtl/core/rwcp_step.sv
// Per-byte next-state and result logic of the RIFF/WAVE chunk header parser.
`timescale 1ns / 1ps
`default_nettype none

module rwcp_step (
  input  wire rwcp_pkg::state_t cur,
  input  wire logic [7:0]       byte_value,
  input  wire logic             start_flag,
  input  wire logic [31:0]      buffer_length,
  input  wire logic [31:0]      expected_rate_hz,
  output rwcp_pkg::state_t      nxt,
  output rwcp_pkg::res_t        res
);
  import rwcp_pkg::*;

  localparam logic [31:0] TAG_FMT  = 32'h666D7420;
  localparam logic [31:0] TAG_DATA = 32'h64617461;

  function automatic logic [7:0] riff_byte(input logic [3:0] k);
    logic [7:0] v;
    v = 8'h00;
    case (k)
      4'd0:  v = 8'h52;
      4'd1:  v = 8'h49;
      4'd2:  v = 8'h46;
      4'd3:  v = 8'h46;
      4'd8:  v = 8'h57;
      4'd9:  v = 8'h41;
      4'd10: v = 8'h56;
      4'd11: v = 8'h45;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

  state_t      s;
  logic [31:0] tag_w;
  logic [31:0] size_w;
  logic [32:0] skip_dec;
  logic        chk;
  logic [7:0]  exp_b;
  logic        fail;
  logic        ok;
  logic        at_end;

  assign at_end = ({1'b0, s.pos} + 33'd1) >= {1'b0, buffer_length};

  always_comb begin
    s        = start_flag ? STATE_RST : cur;
    nxt      = s;
    fail     = 1'b0;
    ok       = 1'b0;
    tag_w    = (s.shift == 4'd0) ? 32'd0 : s.tag;
    size_w   = (s.shift == 4'd0) ? 32'd0 : s.size;
    skip_dec = (s.skip != 33'd0) ? s.skip - 33'd1 : s.skip;
    chk      = 1'b0;
    exp_b    = 8'h00;

    if (s.shift < 4'd4) begin
      tag_w = {tag_w[23:0], byte_value};
    end else begin
      case (s.shift[1:0])
        2'd0:    size_w[7:0]   = size_w[7:0]   | byte_value;
        2'd1:    size_w[15:8]  = size_w[15:8]  | byte_value;
        2'd2:    size_w[23:16] = size_w[23:16] | byte_value;
        default: size_w[31:24] = size_w[31:24] | byte_value;
      endcase
    end

    case (s.shift)
      4'd0:  begin chk = 1'b1; exp_b = 8'd1; end
      4'd1:  begin chk = 1'b1; exp_b = 8'd0; end
      4'd2:  begin chk = 1'b1; exp_b = 8'd1; end
      4'd3:  begin chk = 1'b1; exp_b = 8'd0; end
      4'd4:  begin chk = 1'b1; exp_b = expected_rate_hz[7:0];   end
      4'd5:  begin chk = 1'b1; exp_b = expected_rate_hz[15:8];  end
      4'd6:  begin chk = 1'b1; exp_b = expected_rate_hz[23:16]; end
      4'd7:  begin chk = 1'b1; exp_b = expected_rate_hz[31:24]; end
      4'd14: begin chk = 1'b1; exp_b = 8'd16; end
      4'd15: begin chk = 1'b1; exp_b = 8'd0;  end
      default: begin chk = 1'b0; exp_b = 8'd0; end
    endcase

    if (!s.decided) begin
      unique case (s.phase)
        PH_RIFF: begin
          if ((s.shift < 4'd4 || s.shift >= 4'd8) && byte_value != riff_byte(s.shift)) begin
            fail = 1'b1;
          end else if (s.shift >= 4'd11) begin
            nxt.shift = 4'd0;
            nxt.phase = PH_HEADER;
          end else begin
            nxt.shift = s.shift + 4'd1;
          end
        end
        PH_HEADER: begin
          nxt.tag  = tag_w;
          nxt.size = size_w;
          if (s.shift < 4'd7) begin
            nxt.shift = s.shift + 4'd1;
          end else if (tag_w == TAG_FMT) begin
            if (size_w < 32'd16 || size_w > buffer_length) begin
              fail = 1'b1;
            end else begin
              nxt.shift = 4'd0;
              nxt.skip  = {1'b0, size_w - 32'd16} + {32'd0, size_w[0]};
              nxt.phase = PH_FMT;
            end
          end else if (tag_w == TAG_DATA) begin
            if (!s.fmt_seen || size_w == 32'd0) begin
              fail = 1'b1;
            end else begin
              ok = 1'b1;
            end
          end else if (size_w > buffer_length) begin
            fail = 1'b1;
          end else begin
            nxt.shift = 4'd0;
            nxt.skip  = {1'b0, size_w} + {32'd0, size_w[0]};
            nxt.phase = (size_w == 32'd0) ? PH_HEADER : PH_SKIP;
          end
        end
        PH_FMT: begin
          if (chk && exp_b != byte_value) begin
            fail = 1'b1;
          end else if (s.shift == 4'd15) begin
            nxt.fmt_seen = 1'b1;
            nxt.shift    = 4'd0;
            nxt.phase    = (s.skip == 33'd0) ? PH_HEADER : PH_SKIP;
          end else begin
            nxt.shift = s.shift + 4'd1;
          end
        end
        PH_SKIP: begin
          nxt.skip = skip_dec;
          if (skip_dec == 33'd0) begin
            nxt.shift = 4'd0;
            nxt.phase = PH_HEADER;
          end
        end
      endcase

      if (!ok && !fail && at_end) begin
        fail = 1'b1;
      end
      if (ok || fail) begin
        nxt.decided = 1'b1;
      end else begin
        nxt.pos = s.pos + 32'd1;
      end
    end

    res.valid  = ok | fail;
    res.ok     = ok;
    res.offset = ok ? s.pos + 32'd1 : 32'd0;
    res.length = ok ? size_w : 32'd0;
  end

endmodule

`default_nettype wire

>>> rtl/core/riff_wav_chunk_parser_core.sv
// Top level of the RIFF/WAVE chunk header parser: stream ports, registers, result stage.
//
//   channel  direction  tdata                                 tuser
//   in_      slave      [7:0] byte_value                      start_flag
//   out_     master     [31:0] data_offset, [63:32] data_length  parse_ok
//   cfg_     slave      cfg_index selects register, cfg_data holds the value
//
// One byte per cycle while in_tready is high: each transaction is parsed in the cycle it is taken.
// A result is registered at the edge that takes its byte and shows on out_ in the next cycle.
// The output register drains in the same cycle a new byte is taken, so a stall
// on out_ only holds in_ while a result is actually waiting.
// Reset returns both registers to 512 and 16000 and the parser to the RIFF tag.
`timescale 1ns / 1ps
`default_nettype none

module riff_wav_chunk_parser_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] byte_value
  input  wire logic        in_tuser,   // [0] start_flag
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [63:0]      out_tdata,  // [31:0] data_offset, [63:32] data_length
  output logic             out_tuser,  // [0] parse_ok
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);
  import rwcp_pkg::*;

  state_t      state_r;
  state_t      state_nxt;
  res_t        res;
  logic [31:0] buffer_length_r;
  logic [31:0] expected_rate_r;
  logic        out_tvalid_r;
  logic        out_tvalid_nxt;
  logic [63:0] out_tdata_r;
  logic        out_tuser_r;
  logic        in_accept;

  rwcp_step u_step (
    .cur              (state_r),
    .byte_value       (in_tdata),
    .start_flag       (in_tuser),
    .buffer_length    (buffer_length_r),
    .expected_rate_hz (expected_rate_r),
    .nxt              (state_nxt),
    .res              (res)
  );

  assign in_tready = !out_tvalid_r || out_tready;
  assign in_accept = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  always_comb begin
    if (in_accept) begin
      out_tvalid_nxt = res.valid;
    end else begin
      out_tvalid_nxt = out_tvalid_r && !out_tready;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= STATE_RST;
      out_tvalid_r    <= 1'b0;
      buffer_length_r <= BUFFER_LENGTH_RST;
      expected_rate_r <= EXPECTED_RATE_RST;
    end else begin
      out_tvalid_r <= out_tvalid_nxt;
      if (in_accept) begin
        state_r <= state_nxt;
      end
      if (cfg_valid) begin
        case (cfg_index)
          REG_BUFFER_LENGTH: buffer_length_r <= cfg_data;
          REG_EXPECTED_RATE: expected_rate_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && res.valid) begin
      out_tdata_r <= {res.length, res.offset};
      out_tuser_r <= res.ok;
    end
  end

  a_decided_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && state_r.decided && !in_tuser |-> !res.valid)
    else $error("result raised after the buffer was already decided");

  a_result_marks_decided: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && res.valid |=> state_r.decided && out_tvalid_r)
    else $error("result not registered or buffer not marked decided");

  a_ok_has_length: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid_r && out_tuser_r |-> out_tdata_r[63:32] != 32'd0)
    else $error("success reported with an empty data chunk");

  a_fail_zero_payload: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid_r && !out_tuser_r |-> out_tdata_r == 64'd0)
    else $error("failure reported with non-zero offset or length");

endmodule

`default_nettype wire

>>> tb/testbench.sv
// Self-checking testbench for the RIFF/WAVE chunk header parser core.
`timescale 1ns / 1ps

module testbench;
  import rwcp_pkg::*;

  localparam logic [31:0] TAG_RIFF = "RIFF";
  localparam logic [31:0] TAG_WAVE = "WAVE";
  localparam logic [31:0] TAG_FMT  = "fmt ";
  localparam logic [31:0] TAG_DATA = "data";
  localparam logic [31:0] TAG_LIST = "LIST";
  localparam int CYCLE_LIMIT  = 200000;
  localparam int LONG_HOLD    = 400;
  localparam int DRAIN_CYCLES = 4;
  localparam int PHASE_BYTES  = 100;
  localparam int PHASE_RESULTS = 2;

  typedef struct {
    logic        ok;
    logic [31:0] offset;
    logic [31:0] length;
  } parse_result_t;

  class wav_header_scoreboard;
    logic [31:0]   buffer_length;
    logic [31:0]   expected_rate;
    logic [31:0]   byte_pos;
    phase_t        parse_phase;
    int unsigned   field_idx;
    logic [31:0]   chunk_tag;
    logic [31:0]   chunk_size;
    logic [32:0]   skip_left;
    bit            fmt_seen;
    bit            decided;
    parse_result_t expected_results[$];
    int unsigned   results_predicted;
    int unsigned   error_count;

    function new();
      buffer_length = BUFFER_LENGTH_RST;
      expected_rate = EXPECTED_RATE_RST;
      results_predicted = 0;
      error_count = 0;
      restart();
    endfunction

    function void restart();
      byte_pos = '0;
      parse_phase = PH_RIFF;
      field_idx = 0;
      chunk_tag = '0;
      chunk_size = '0;
      skip_left = '0;
      fmt_seen = 1'b0;
      decided = 1'b0;
    endfunction

    function void set_register(logic [1:0] index, logic [31:0] value);
      if (index == REG_BUFFER_LENGTH) buffer_length = value;
      else if (index == REG_EXPECTED_RATE) expected_rate = value;
    endfunction

    function void enter_body(logic [32:0] count);
      field_idx = 0;
      skip_left = count;
      parse_phase = (count == 0) ? PH_HEADER : PH_SKIP;
    endfunction

    function int riff_expect(int unsigned k);
      case (k)
        0, 1, 2, 3: return TAG_RIFF[31 - 8 * k -: 8];
        8, 9, 10, 11: return TAG_WAVE[31 - 8 * (k - 8) -: 8];
        default: return -1;
      endcase
    endfunction

    function int fmt_expect(int unsigned k);
      case (k)
        0, 2: return 1;
        1, 3, 15: return 0;
        4, 5, 6, 7: return (expected_rate >> (8 * (k - 4))) & 32'hFF;
        14: return 16;
        default: return -1;
      endcase
    endfunction

    function void note_byte(logic [7:0] b, logic first);
      bit            fail;
      bit            ok;
      int            e;
      parse_result_t res;
      fail = 1'b0;
      ok = 1'b0;
      res.ok = 1'b0;
      res.offset = '0;
      res.length = '0;
      if (first) restart();
      if (decided) return;
      case (parse_phase)
        PH_RIFF: begin
          e = riff_expect(field_idx);
          if (e >= 0 && b != e[7:0]) fail = 1'b1;
          else if (field_idx >= 11) begin
            field_idx = 0;
            parse_phase = PH_HEADER;
          end else field_idx++;
        end
        PH_HEADER: begin
          if (field_idx == 0) begin
            chunk_tag = '0;
            chunk_size = '0;
          end
          if (field_idx < 4) chunk_tag = {chunk_tag[23:0], b};
          else chunk_size |= {24'd0, b} << (8 * ((field_idx - 4) & 3));
          if (field_idx < 7) field_idx++;
          else if (chunk_tag == TAG_FMT) begin
            if (chunk_size < 16 || chunk_size > buffer_length) fail = 1'b1;
            else begin
              field_idx = 0;
              skip_left = {1'b0, chunk_size} - 33'd16 + chunk_size[0];
              parse_phase = PH_FMT;
            end
          end else if (chunk_tag == TAG_DATA) begin
            if (!fmt_seen || chunk_size == 0) fail = 1'b1;
            else begin
              ok = 1'b1;
              res.ok = 1'b1;
              res.offset = byte_pos + 32'd1;
              res.length = chunk_size;
            end
          end else if (chunk_size > buffer_length) fail = 1'b1;
          else enter_body({1'b0, chunk_size} + chunk_size[0]);
        end
        PH_FMT: begin
          e = fmt_expect(field_idx);
          if (e >= 0 && b != e[7:0]) fail = 1'b1;
          else if (field_idx >= 15) begin
            fmt_seen = 1'b1;
            enter_body(skip_left);
          end else field_idx++;
        end
        default: begin
          if (skip_left != 0) skip_left--;
          if (skip_left == 0) enter_body('0);
        end
      endcase
      if (!ok && !fail && {1'b0, byte_pos} + 33'd1 >= {1'b0, buffer_length}) fail = 1'b1;
      if (ok || fail) begin
        decided = 1'b1;
        expected_results.push_back(res);
        results_predicted++;
      end else byte_pos++;
    endfunction

    function void report_field(string name, logic [31:0] want, logic [31:0] got);
      error_count++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    endfunction

    function void check_result(logic ok, logic [31:0] offset, logic [31:0] length);
      parse_result_t want;
      if (expected_results.size() == 0) begin
        error_count++;
        $display("%0t: unexpected result, expected none, got ok=%0b offset=%0d length=%0d",
                 $time, ok, offset, length);
        return;
      end
      want = expected_results.pop_front();
      if (ok !== want.ok) report_field("parse_ok", want.ok, ok);
      if (offset !== want.offset) report_field("data_offset", want.offset, offset);
      if (length !== want.length) report_field("data_length", want.length, length);
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic        in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [63:0] out_tdata;
  logic        out_tuser;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;

  wav_header_scoreboard sb;
  logic [7:0]  wav_image[$];
  bit          image_has_start;
  int          sender_idle_pct;
  int          receiver_stall_pct;
  int          hold_requests;
  int unsigned bytes_sent;
  int unsigned cycle_count;

  riff_wav_chunk_parser_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  // sample both channels at the rising edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) sb.note_byte(in_tdata, in_tuser);
      if (out_tvalid && out_tready)
        sb.check_result(out_tuser, out_tdata[31:0], out_tdata[63:32]);
    end
  end

  initial begin
    int holds_served;
    int hold_left;
    holds_served = 0;
    hold_left = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (holds_served != hold_requests) begin
        holds_served++;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else out_tready <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  function automatic logic [7:0] random_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic void put_random_bytes(int count);
    repeat (count) wav_image.push_back(random_byte());
  endfunction

  function automatic void put_tag(logic [31:0] tag_word);
    for (int i = 3; i >= 0; i--) wav_image.push_back(tag_word[8 * i +: 8]);
  endfunction

  function automatic void put_le16(logic [15:0] value);
    wav_image.push_back(value[7:0]);
    wav_image.push_back(value[15:8]);
  endfunction

  function automatic void put_le32(logic [31:0] value);
    for (int i = 0; i < 4; i++) wav_image.push_back(value[8 * i +: 8]);
  endfunction

  function automatic void put_filler_chunk(bit oversized);
    logic [31:0] chunk_len;
    case ($urandom_range(0, 4))
      0: chunk_len = 0;
      1: chunk_len = $urandom;
      default: chunk_len = $urandom_range(1, 9);
    endcase
    if (oversized) chunk_len = sb.buffer_length + 32'd1;
    put_tag($urandom_range(0, 1) ? TAG_LIST : $urandom);
    put_le32(chunk_len);
    put_random_bytes((chunk_len > 40) ? 40 : chunk_len + chunk_len[0]);
  endfunction

  function automatic void build_wav_image();
    int          kind;
    int          cut;
    logic [31:0] fmt_len;
    logic [31:0] body_size;
    kind = $urandom_range(0, 19);
    wav_image.delete();
    image_has_start = 1'b1;
    if (kind == 19) begin
      put_random_bytes($urandom_range(1, 16));
      image_has_start = $urandom_range(0, 1);
      return;
    end
    put_tag(TAG_RIFF);
    put_le32($urandom);
    put_tag(TAG_WAVE);
    if ($urandom_range(0, 3) == 0) put_filler_chunk(1'b0);
    if (kind != 14) begin
      case ($urandom_range(0, 5))
        0: fmt_len = 17;
        1: fmt_len = 18;
        2: fmt_len = 24;
        default: fmt_len = 16;
      endcase
      if (kind == 12) fmt_len = $urandom_range(0, 15);
      if (kind == 13) fmt_len = sb.buffer_length + 32'd1 + $urandom_range(0, 3);
      put_tag(TAG_FMT);
      put_le32(fmt_len);
      put_le16(16'd1);
      put_le16(16'd1);
      put_le32(sb.expected_rate);
      put_le32($urandom);
      put_le16(16'($urandom));
      put_le16(16'd16);
      if (fmt_len >= 16 && fmt_len <= 64) put_random_bytes(fmt_len - 16 + fmt_len[0]);
    end
    if ($urandom_range(0, 3) == 0 || kind == 16) put_filler_chunk(kind == 16);
    case ($urandom_range(0, 3))
      0: body_size = 32'd1;
      1: body_size = 32'hFFFF_FFFF;
      2: body_size = $urandom;
      default: body_size = $urandom_range(1, 4096);
    endcase
    if (kind == 15) body_size = '0;
    put_tag(TAG_DATA);
    put_le32(body_size);
    put_random_bytes($urandom_range(0, 2));
    if (kind == 10 || kind == 11)
      wav_image[$urandom_range(0, wav_image.size() - 1)] ^= 8'($urandom_range(1, 255));
    if (kind == 17 || kind == 18) begin
      cut = $urandom_range(1, wav_image.size() - 1);
      while (wav_image.size() > cut) wav_image.pop_back();
    end
  endfunction

  // call at a falling edge; returns at the falling edge after the transaction
  task automatic send_byte(input logic [7:0] value, input logic first);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= value;
    in_tuser  <= first;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    bytes_sent++;
  endtask

  task automatic send_image();
    foreach (wav_image[i]) send_byte(wav_image[i], (i == 0) && image_has_start);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (sb.expected_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_register(input logic [1:0] index, input logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    sb.set_register(index, value);
    @(negedge clk);
  endtask

  task automatic set_registers(input logic [31:0] length, input logic [31:0] rate);
    write_register(REG_BUFFER_LENGTH, length);
    write_register(REG_EXPECTED_RATE, rate);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [31:0] length;
    logic [31:0] rate;
    int unsigned goal;
    int unsigned phase_start;
    sb = new();
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = REG_BUFFER_LENGTH;
    cfg_data = '0;
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    hold_requests = 0;
    bytes_sent = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // first byte after reset without a start flag, then field extremes
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte("R", 1'b1);
    send_byte("I", 1'b0);
    send_byte("F", 1'b0);
    send_byte("Q", 1'b0);
    // data chunk with no fmt chunk ahead of it
    wav_image.delete();
    put_tag(TAG_RIFF);
    put_le32(32'hFFFF_FFFF);
    put_tag(TAG_WAVE);
    put_tag(TAG_DATA);
    put_le32(32'd8);
    image_has_start = 1'b1;
    send_image();
    wait_drained();
    set_registers(32'd0, EXPECTED_RATE_RST);
    send_byte("R", 1'b1);
    wait_drained();
    set_registers(32'd1, EXPECTED_RATE_RST);
    send_byte("R", 1'b1);

    for (int p = 0; p < 8; p++) begin
      wait_drained();
      case (p)
        0: begin length = 32'd512;              rate = 32'd16000;      end
        1: begin length = 32'd44;               rate = 32'd44100;      end
        2: begin length = 32'hFFFF_FFFF;        rate = 32'hFFFF_FFFF;  end
        3: begin length = $urandom_range(20, 120); rate = 32'd0;       end
        4: begin length = 32'd1;                rate = $urandom;       end
        5: begin length = 32'd512;              rate = 32'd8000;       end
        6: begin length = 32'd60;               rate = 32'd16000;      end
        default: begin length = $urandom_range(200, 4000); rate = $urandom; end
      endcase
      set_registers(length, rate);
      sender_idle_pct    = (p % 4 == 1) ? 68 : (p % 4 == 3) ? 7 : 0;
      receiver_stall_pct = (p % 4 == 2) ? 68 : (p % 4 == 3) ? 7 : 0;
      if (p == 0) begin
        // hold the result side off while single-byte failures keep arriving
        @(posedge clk);
        hold_requests++;
        @(negedge clk);
        repeat (40) send_byte(random_byte(), 1'b1);
      end
      goal = sb.results_predicted + PHASE_RESULTS;
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < PHASE_BYTES || sb.results_predicted < goal) begin
        build_wav_image();
        send_image();
      end
    end

    wait_drained();
    repeat (10) @(negedge clk);
    if (sb.error_count == 0 && sb.expected_results.size() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
